// File: src/least_loaded_heap_balancer_macros.svh
// ----------------------------------------------------------------------------
// Least-loaded heap balancer assertion macros
// These macros give shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_HEAP_BALANCER_MACROS_SVH
`define LEAST_LOADED_HEAP_BALANCER_MACROS_SVH

// This macro checks that a property holds at every rising clock edge outside reset.
`define LHB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// This macro checks that a consequent holds in the cycle after an antecedent.
`define LHB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lhb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-loaded heap balancer package
// Shared widths, codes and types of the balancer.
// ----------------------------------------------------------------------------
package lhb_pkg;

   localparam int OP_W        = 2;
   localparam int SAMPLE_W    = 24;
   localparam int MASK_W      = 16;
   localparam int ID_W        = 4;
   localparam int LOAD_W      = 24;
   localparam int CNT_W       = 7;
   localparam int WEIGHT_W    = 7;
   localparam int ITEM_CNT_W  = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int ACC_W       = 32;
   localparam int PROD_W      = 2 * ACC_W;
   localparam int DIVISOR_W   = 7;
   localparam int STEP_W      = 5;

   localparam int WARMUP_SAMPLES = 100;

   // Exact unsigned division by 100 for any 32-bit dividend.
   localparam logic [ACC_W-1:0] DIV100_MUL   = 32'h51EB851F;
   localparam int               DIV100_SHIFT = 37;

   localparam logic [OP_W-1:0] OP_CHECKOUT = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECKIN  = 2'd2;
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EWMA_WEIGHT = 1'd1;

   localparam logic [ITEM_CNT_W-1:0] ITEM_COUNT_RESET = 5'd16;
   localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET     = 7'd10;
   localparam logic [WEIGHT_W-1:0]   PERCENT          = 7'd100;

   typedef struct packed {
      logic              avail;
      logic [LOAD_W-1:0] load;
   } cand_type;

   typedef struct packed {
      logic                 start;
      logic [ACC_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

endpackage

// File: src/lhb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balancer request channel
// Carries one operation item with its sample and availability mask.
// ----------------------------------------------------------------------------
interface lhb_req_if;
   logic                            valid;
   logic                            ready;
   logic [lhb_pkg::OP_W-1:0]        op;
   logic [lhb_pkg::SAMPLE_W-1:0]    sample;
   logic [lhb_pkg::MASK_W-1:0]      avail_mask;

   modport source (output valid, op, sample, avail_mask, input ready);
   modport sink (input valid, op, sample, avail_mask, output ready);
endinterface

// File: src/lhb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balancer response channel
// Carries one result item per request item.
// ----------------------------------------------------------------------------
interface lhb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lhb_pkg::ID_W-1:0]    item_id;
   logic                        got_item;
   logic                        refused;

   modport source (output valid, item_id, got_item, refused, input ready);
   modport sink (input valid, item_id, got_item, refused, output ready);
endinterface

// File: src/lhb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balancer shared divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lhb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  lhb_pkg::div_req_type         req,
   output logic [lhb_pkg::ACC_W-1:0]    quotient,
   output logic                         done
);
   import lhb_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [ACC_W-1:0]     num_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] den_ff;
   logic [DIVISOR_W:0]   trial;
   logic                 ge;

   assign trial = {rem_ff, num_ff[ACC_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(ACC_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff <= req.dividend;
         den_ff <= req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[ACC_W-2:0], ge};
         rem_ff <= ge ? DIVISOR_W'(trial - {1'b0, den_ff}) : trial[DIVISOR_W-1:0];
      end
   end

   assign quotient = num_ff;
   assign done     = done_ff;
endmodule

// File: src/lhb_better.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Balancer rank compare unit
// Tells whether one candidate ranks strictly before another.
// ----------------------------------------------------------------------------
module lhb_better (
   input  lhb_pkg::cand_type a,
   input  lhb_pkg::cand_type b,
   output logic              a_better
);
   import lhb_pkg::*;

   assign a_better = (a.avail && !b.avail) || ((a.avail == b.avail) && (a.load < b.load));
endmodule

// File: src/least_loaded_heap_balancer.sv
`timescale 1ns / 1ps
`include "least_loaded_heap_balancer_macros.svh"
// ----------------------------------------------------------------------------
// Least-loaded heap balancer
// Min-heap of servers keyed by a smoothed load, with checkout, load sample
// and checkin operations run by a small sequencer over shared units.
// ----------------------------------------------------------------------------
//   Channel   Direction  Contents
//   req_chan  in         op, sample, avail_mask
//   rsp_chan  out        item_id, got_item, refused
//   csr_*     in         item_count (index 0), ewma_weight (index 1)
//
// A checkout visits every heap node from the last up to the root, reading and
// then weighing each one. A load sample waits for one pass of the divider
// during warm-up and skips the divider once the sample count is past warm-up.
// A checkin reads, compares and swaps once for each heap level it moves down.
// Reset is synchronous and restores the initial heap order.
// A new item is taken once the previous result item has been taken.
// ----------------------------------------------------------------------------
module least_loaded_heap_balancer #(
   parameter int MAX_SERVERS    = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   lhb_req_if.sink                           req_chan,
   lhb_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [lhb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lhb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lhb_pkg::*;

   localparam int PW = $clog2(MAX_SERVERS + 1);
   localparam int SW = $clog2(MAX_SERVERS);
   localparam int IW = (PW + 1 > ITEM_CNT_W + 1) ? PW + 1 : ITEM_CNT_W + 1;

   typedef struct packed {
      logic [SW-1:0]     srv;
      logic [LOAD_W-1:0] load;
      logic [CNT_W-1:0]  cnt;
   } slot_type;

   typedef struct packed {
      logic [PW-1:0] idx;
      logic [SW-1:0] srv;
      cand_type      cand;
   } best_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SRCH_RD, ST_SRCH_EV, ST_ADD_RD, ST_ADD_DIVQ, ST_ADD_WAITQ,
      ST_ADD_MUL1, ST_ADD_MUL2, ST_ADD_DIVD, ST_ADD_WAITD, ST_SIFT_RD,
      ST_SIFT_RD2, ST_SIFT_CMP1, ST_SIFT_CMP2, ST_SIFT_SW1, ST_SIFT_SW2
   } state_type;

   state_type            state_ff;
   slot_type             slot_ff [MAX_SERVERS+1];
   best_type             best_ff [MAX_SERVERS+1];
   logic [PW-1:0]        co_ff;
   logic [ITEM_CNT_W-1:0] item_count_ff;
   logic [WEIGHT_W-1:0]  weight_ff;
   logic [SAMPLE_W-1:0]  sample_ff;
   logic [MASK_W-1:0]    mask_ff;
   logic [IW-1:0]        n_ff;
   logic [IW-1:0]        p_ff;
   logic [IW-1:0]        m_idx_ff;
   slot_type             pv_ff;
   slot_type             c0_ff;
   slot_type             c1_ff;
   slot_type             m_ff;
   best_type             l_ff;
   best_type             r_ff;
   logic [WEIGHT_W-1:0]  w_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic                 rsp_valid_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic                 rsp_got_ff;
   logic                 rsp_ref_ff;

   logic [IW-1:0]        ic;
   logic [IW-1:0]        n_in;
   logic [IW-1:0]        c2;
   logic [IW-1:0]        c3;
   logic [PW-1:0]        ap;
   logic [PW-1:0]        a2;
   logic [PW-1:0]        a3;
   logic [CNT_W-1:0]     cnt_in;
   logic [WEIGHT_W-1:0]  wsat;
   logic [WEIGHT_W-1:0]  q7;
   logic [WEIGHT_W-1:0]  w_in;
   logic [WEIGHT_W-1:0]  mul_a;
   logic [LOAD_W-1:0]    mul_b;
   logic [ACC_W-1:0]     prod;
   logic [PROD_W-1:0]    scaled;
   cand_type             cmp_a;
   cand_type             cmp_b;
   logic                 a_better;
   best_type             pbest;
   best_type             chosen;
   div_req_type          div_req;
   logic [ACC_W-1:0]     div_q;
   logic                 div_done;
   logic                 accept;

   function automatic cand_type cand_of(slot_type s, logic [MASK_W-1:0] mask);
      logic [6:0] e;
      cand_type   c;
      e = 7'(s.srv);
      c.avail = (e < 7'd16) && mask[e[3:0]];
      c.load  = s.load;
      return c;
   endfunction

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.item_id  = rsp_id_ff;
   assign rsp_chan.got_item = rsp_got_ff;
   assign rsp_chan.refused  = rsp_ref_ff;

   assign ic   = IW'(item_count_ff);
   assign n_in = (ic == '0) ? IW'(1) : ((ic > IW'(MAX_SERVERS)) ? IW'(MAX_SERVERS) : ic);
   assign c2   = {p_ff[IW-2:0], 1'b0};
   assign c3   = {p_ff[IW-2:0], 1'b1};
   assign ap   = p_ff[PW-1:0];
   assign a2   = (c2 <= IW'(MAX_SERVERS)) ? c2[PW-1:0] : '0;
   assign a3   = (c3 <= IW'(MAX_SERVERS)) ? c3[PW-1:0] : '0;

   assign cnt_in = (pv_ff.cnt < CNT_W'(WARMUP_SAMPLES + 1)) ? pv_ff.cnt + 1'b1 : pv_ff.cnt;
   assign wsat   = (weight_ff > PERCENT) ? PERCENT : weight_ff;
   assign q7     = div_q[WEIGHT_W-1:0];
   assign w_in   = (q7 > wsat) ? ((q7 > PERCENT) ? PERCENT : q7) : wsat;

   assign mul_a = (state_ff == ST_ADD_MUL1) ? PERCENT - w_ff : w_ff;
   assign mul_b = (state_ff == ST_ADD_MUL1) ? pv_ff.load : sample_ff;
   assign prod  = ACC_W'(mul_a) * ACC_W'(mul_b);

   assign scaled = PROD_W'(acc_ff) * PROD_W'(DIV100_MUL);

   always_comb begin
      div_req.start    = (state_ff == ST_ADD_DIVQ);
      div_req.dividend = ACC_W'(WARMUP_SAMPLES);
      div_req.divisor  = cnt_in;
   end

   always_comb begin
      case (state_ff)
         ST_SRCH_EV: begin
            cmp_a = l_ff.cand;
            cmp_b = r_ff.cand;
         end
         ST_SIFT_CMP1: begin
            cmp_a = cand_of(c0_ff, mask_ff);
            cmp_b = cand_of(c1_ff, mask_ff);
         end
         default: begin
            cmp_a = cand_of(m_ff, mask_ff);
            cmp_b = cand_of(pv_ff, mask_ff);
         end
      endcase
   end

   always_comb begin
      pbest.idx  = ap;
      pbest.srv  = pv_ff.srv;
      pbest.cand = cand_of(pv_ff, mask_ff);
      if (pbest.cand.avail || (c2 > n_ff)) begin
         chosen = pbest;
      end else if (c2 == n_ff || a_better) begin
         chosen = l_ff;
      end else begin
         chosen = r_ff;
      end
   end

   lhb_better u_better (
      .a        (cmp_a),
      .b        (cmp_b),
      .a_better (a_better)
   );

   lhb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .quotient (div_q),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         co_ff         <= '0;
         item_count_ff <= ITEM_COUNT_RESET;
         weight_ff     <= WEIGHT_RESET;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i <= MAX_SERVERS; i++) begin
            slot_ff[i].srv  <= (i == 0) ? '0 : SW'(i - 1);
            slot_ff[i].load <= '0;
            slot_ff[i].cnt  <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ITEM_COUNT:  item_count_ff <= csr_wdata[ITEM_CNT_W-1:0];
               CSR_EWMA_WEIGHT: weight_ff <= csr_wdata[WEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sample_ff  <= req_chan.sample;
                  mask_ff    <= req_chan.avail_mask;
                  n_ff       <= n_in;
                  rsp_id_ff  <= '0;
                  rsp_got_ff <= 1'b0;
                  rsp_ref_ff <= 1'b0;
                  case (req_chan.op)
                     OP_CHECKOUT: begin
                        if (co_ff != '0) begin
                           rsp_ref_ff   <= 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           p_ff     <= n_in;
                           state_ff <= ST_SRCH_RD;
                        end
                     end
                     OP_ADD: begin
                        if (co_ff != '0) begin
                           p_ff     <= IW'(co_ff);
                           state_ff <= ST_ADD_RD;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     OP_CHECKIN: begin
                        if (co_ff != '0) begin
                           co_ff    <= '0;
                           p_ff     <= IW'(co_ff);
                           state_ff <= ST_SIFT_RD;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            ST_SRCH_RD: begin
               pv_ff    <= slot_ff[ap];
               l_ff     <= best_ff[a2];
               r_ff     <= best_ff[a3];
               state_ff <= ST_SRCH_EV;
            end
            ST_SRCH_EV: begin
               best_ff[ap] <= chosen;
               if (p_ff == IW'(1)) begin
                  if (chosen.cand.avail) begin
                     co_ff      <= chosen.idx;
                     rsp_id_ff  <= ID_W'(chosen.srv);
                     rsp_got_ff <= 1'b1;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  p_ff     <= p_ff - 1'b1;
                  state_ff <= ST_SRCH_RD;
               end
            end
            ST_ADD_RD: begin
               pv_ff    <= slot_ff[ap];
               state_ff <= ST_ADD_DIVQ;
            end
            ST_ADD_DIVQ: begin
               slot_ff[ap].cnt  <= cnt_in;
               if (cnt_in <= CNT_W'(WARMUP_SAMPLES)) begin
                  state_ff <= ST_ADD_WAITQ;
               end else begin
                  w_ff     <= wsat;
                  state_ff <= ST_ADD_MUL1;
               end
            end
            ST_ADD_WAITQ: begin
               if (div_done) begin
                  w_ff     <= w_in;
                  state_ff <= ST_ADD_MUL1;
               end
            end
            ST_ADD_MUL1: begin
               acc_ff   <= prod;
               state_ff <= ST_ADD_MUL2;
            end
            ST_ADD_MUL2: begin
               acc_ff   <= acc_ff + prod;
               state_ff <= ST_ADD_DIVD;
            end
            ST_ADD_DIVD: begin
               acc_ff   <= ACC_W'(scaled >> DIV100_SHIFT);
               state_ff <= ST_ADD_WAITD;
            end
            ST_ADD_WAITD: begin
               slot_ff[ap].load <= acc_ff[LOAD_W-1:0];
               rsp_valid_ff     <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            ST_SIFT_RD: begin
               if (c2 > n_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  pv_ff    <= slot_ff[ap];
                  c0_ff    <= slot_ff[a2];
                  m_ff     <= slot_ff[a2];
                  m_idx_ff <= c2;
                  state_ff <= (c2 == n_ff) ? ST_SIFT_CMP2 : ST_SIFT_RD2;
               end
            end
            ST_SIFT_RD2: begin
               c1_ff    <= slot_ff[a3];
               state_ff <= ST_SIFT_CMP1;
            end
            ST_SIFT_CMP1: begin
               if (!a_better) begin
                  m_ff     <= c1_ff;
                  m_idx_ff <= c3;
               end
               state_ff <= ST_SIFT_CMP2;
            end
            ST_SIFT_CMP2: begin
               if (a_better) begin
                  state_ff <= ST_SIFT_SW1;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SIFT_SW1: begin
               slot_ff[ap] <= m_ff;
               state_ff    <= ST_SIFT_SW2;
            end
            ST_SIFT_SW2: begin
               slot_ff[m_idx_ff[PW-1:0]] <= pv_ff;
               p_ff     <= m_idx_ff;
               state_ff <= ST_SIFT_RD;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `LHB_ASSERT(a_no_refused_got, clock, reset, rsp_chan.valid |-> !(rsp_chan.refused && rsp_chan.got_item), "A refused item also reports a server.")
   `LHB_ASSERT(a_got_has_slot, clock, reset, (rsp_chan.valid && rsp_chan.got_item) |-> (co_ff != '0), "A granted server has no checked-out slot.")
   `LHB_ASSERT(a_slot_in_range, clock, reset, co_ff <= PW'(MAX_SERVERS), "The checked-out slot is beyond the heap storage.")
   `LHB_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_chan.ready, "The block accepts a new item before finishing the last one.")
endmodule

// File: test/least_loaded_heap_balancer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-loaded heap balancer testbench
// Drives checkout, load sample, checkin and reserved items through the request
// channel under random idling and one long response hold-off. Every response is
// compared with a behavioral model of the heap kept in the testbench.
// ----------------------------------------------------------------------------
module least_loaded_heap_balancer_test;
   import lhb_pkg::*;

   localparam int NSRV = 16;
   localparam int MAX_CYCLES = 2000000;

   typedef struct packed {
      logic [ID_W-1:0] item_id;
      logic            got_item;
      logic            refused;
   } reply_t;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [SAMPLE_W-1:0] sample;
      logic [MASK_W-1:0]   mask;
      bit                  typed;
      reply_t              reply;
   } row_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lhb_req_if req_chan ();
   lhb_rsp_if rsp_chan ();

   least_loaded_heap_balancer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [3:0]        heap_server [1:NSRV];
   logic [LOAD_W-1:0] heap_load [1:NSRV];
   logic [CNT_W-1:0]  heap_count [1:NSRV];
   int unsigned       held_slot;
   int unsigned       servers;
   int unsigned       weight_pct;
   logic [MASK_W-1:0] live_mask;

   reply_t replies_due[$];
   int unsigned mismatches = 0;
   int unsigned table_errors;
   int unsigned replies_seen = 0;
   int unsigned items_sent;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit hold_off;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned heap_size();
      if (servers == 0) return 1;
      if (servers > NSRV) return NSRV;
      return servers;
   endfunction

   function automatic bit slot_live(int unsigned p);
      return live_mask[heap_server[p]];
   endfunction

   function automatic bit ranks_first(int unsigned a, int unsigned b);
      bit aa;
      bit ba;
      aa = slot_live(a);
      ba = slot_live(b);
      if (aa != ba) return aa;
      return heap_load[a] < heap_load[b];
   endfunction

   function automatic int unsigned find_least(int unsigned p, int unsigned n);
      int unsigned l;
      int unsigned r;
      if (slot_live(p) || n < 2 * p) return p;
      if (n == 2 * p) return find_least(2 * p, n);
      l = find_least(2 * p, n);
      r = find_least(2 * p + 1, n);
      return ranks_first(l, r) ? l : r;
   endfunction

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [3:0] s;
      logic [LOAD_W-1:0] l;
      logic [CNT_W-1:0] c;
      s = heap_server[a]; l = heap_load[a]; c = heap_count[a];
      heap_server[a] = heap_server[b]; heap_load[a] = heap_load[b];
      heap_count[a] = heap_count[b];
      heap_server[b] = s; heap_load[b] = l; heap_count[b] = c;
   endfunction

   function automatic void sink_slot(int unsigned p, int unsigned n);
      int unsigned m;
      while (n >= 2 * p) begin
         m = (n == 2 * p || ranks_first(2 * p, 2 * p + 1)) ? 2 * p : 2 * p + 1;
         if (!ranks_first(m, p)) return;
         swap_slots(p, m);
         p = m;
      end
   endfunction

   function automatic reply_t balance_step(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                                           logic [MASK_W-1:0] mask);
      reply_t r;
      int unsigned n;
      int unsigned p;
      int unsigned cnt;
      int unsigned w;
      longint unsigned acc;
      r = '0;
      n = heap_size();
      live_mask = mask;
      if (op == OP_CHECKOUT) begin
         if (held_slot != 0) begin
            r.refused = 1'b1;
         end else begin
            p = find_least(1, n);
            if (slot_live(p)) begin
               held_slot = p;
               r.item_id = heap_server[p];
               r.got_item = 1'b1;
            end
         end
      end else if (op == OP_ADD) begin
         if (held_slot != 0) begin
            p = held_slot;
            cnt = heap_count[p];
            w = weight_pct > 100 ? 100 : weight_pct;
            if (cnt < 101) cnt++;
            heap_count[p] = CNT_W'(cnt);
            if (cnt <= 100 && 100 / cnt > w) w = 100 / cnt;
            acc = longint'(100 - w) * heap_load[p] + longint'(w) * sample;
            heap_load[p] = LOAD_W'(acc / 100);
         end
      end else if (op == OP_CHECKIN) begin
         if (held_slot != 0) begin
            p = held_slot;
            held_slot = 0;
            sink_slot(p, n);
         end
      end
      return r;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ITEM_COUNT) servers = val[ITEM_CNT_W-1:0];
      else weight_pct = val;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                            logic [MASK_W-1:0] mask, bit typed, reply_t want);
      reply_t r;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.sample <= sample;
      req_chan.avail_mask <= mask;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      r = balance_step(op, sample, mask);
      if (typed && r != want) begin
         table_errors++;
         if (mismatches + table_errors <= 10)
            $display("directed row %0d: table %h, model %h", items_sent, want, r);
      end
      replies_due.push_back(r);
      items_sent++;
   endtask

   task automatic random_item(int unsigned mode);
      logic [OP_W-1:0] op;
      logic [MASK_W-1:0] mask;
      int unsigned k;
      k = $urandom_range(99, 0);
      if (k < 4) op = OP_RESERVED;
      else if (held_slot == 0 && k < 85) op = OP_CHECKOUT;
      else if (held_slot != 0 && k < 70) op = OP_ADD;
      else if (held_slot != 0 && k < 92) op = OP_CHECKIN;
      else op = $urandom_range(2, 0);
      case (mode)
         0: mask = $urandom;
         1: mask = 16'hFFFF;
         default: mask = 16'h1 << $urandom_range(15, 0);
      endcase
      if ($urandom_range(19, 0) == 0) mask = 16'h0;
      send_item(op, $urandom_range(9, 0) == 0 ? $urandom : $urandom_range(4095, 0),
                mask, 1'b0, '0);
   endtask

   row_t rows[] = '{
      '{OP_CHECKIN, 24'h0, 16'hFFFF, 1'b1, '{4'd0, 1'b0, 1'b0}},
      '{OP_ADD, 24'hFFFFFF, 16'hFFFF, 1'b1, '{4'd0, 1'b0, 1'b0}},
      '{OP_CHECKOUT, 24'h0, 16'h0000, 1'b1, '{4'd0, 1'b0, 1'b0}},
      '{OP_CHECKOUT, 24'h0, 16'hFFFF, 1'b1, '{4'd0, 1'b1, 1'b0}},
      '{OP_CHECKOUT, 24'h0, 16'hFFFF, 1'b1, '{4'd0, 1'b0, 1'b1}},
      '{OP_ADD, 24'hFFFFFF, 16'h0, 1'b1, '{4'd0, 1'b0, 1'b0}},
      '{OP_ADD, 24'hFFFFFF, 16'h0, 1'b1, '{4'd0, 1'b0, 1'b0}},
      '{OP_CHECKIN, 24'h0, 16'hFFFF, 1'b1, '{4'd0, 1'b0, 1'b0}},
      '{OP_CHECKOUT, 24'h0, 16'h8000, 1'b1, '{4'd15, 1'b1, 1'b0}},
      '{OP_ADD, 24'h000100, 16'h8000, 1'b0, '0},
      '{OP_RESERVED, 24'hFFFFFF, 16'hFFFF, 1'b1, '{4'd0, 1'b0, 1'b0}},
      '{OP_CHECKIN, 24'h0, 16'hAAAA, 1'b0, '0},
      '{OP_CHECKOUT, 24'hFFFFFF, 16'h5555, 1'b0, '0},
      '{OP_ADD, 24'h0, 16'h0, 1'b0, '0},
      '{OP_CHECKIN, 24'h0, 16'hFFFF, 1'b0, '0},
      '{OP_CHECKOUT, 24'h0, 16'hFFFF, 1'b0, '0},
      '{OP_CHECKIN, 24'h0, 16'h0F0F, 1'b0, '0}
   };

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      reply_t got;
      reply_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.item_id, rsp_chan.got_item, rsp_chan.refused};
         replies_seen++;
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = replies_due.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected id %0d got %b ref %b, actual id %0d got %b ref %b",
                           replies_seen, want.item_id, want.got_item, want.refused,
                           got.item_id, got.got_item, got.refused);
            end
         end
      end
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !hold_off && ($urandom_range(99, 0) >= recv_idle_pct);
   end

   initial begin
      int unsigned phase;
      int unsigned i;
      int unsigned counts[4] = '{1, 16, 3, 0};
      int unsigned weights[4] = '{0, 100, 127, 37};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.op = '0;
      req_chan.sample = '0;
      req_chan.avail_mask = '0;
      hold_off = 1'b0;
      table_errors = 0;
      items_sent = 0;
      send_idle_pct = 13;
      recv_idle_pct = 68;
      for (i = 1; i <= NSRV; i++) begin
         heap_server[i] = 4'(i - 1);
         heap_load[i] = '0;
         heap_count[i] = '0;
      end
      held_slot = 0;
      servers = ITEM_COUNT_RESET;
      weight_pct = WEIGHT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[r]) send_item(rows[r].op, rows[r].sample, rows[r].mask,
                                  rows[r].typed, rows[r].reply);
      wait_drained();

      for (phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 68;
            recv_idle_pct = 13;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         csr_write(CSR_ITEM_COUNT, phase == 5 ? 7'd31 : counts[phase % 4]);
         csr_write(CSR_EWMA_WEIGHT, weights[phase % 4]);
         if (phase == 3) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_off = 1'b0;
               end
               for (i = 0; i < 20; i++) random_item(1);
            join
         end
         for (i = 0; i < 105; i++) random_item(i % 3);
         wait_drained();
      end

      $display("sent %0d items, checked %0d responses over item counts 0..31",
               items_sent, replies_seen);
      $display("weights 0..127, with random, full and single-server masks");
      if (mismatches == 0 && table_errors == 0 && replies_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches + table_errors,
                  replies_due.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
